### rtl/imu_att_pkg.sv
// ----------------------------------------------------------------------------
// imu_att_pkg
// Types, constants and helpers shared by the attitude estimator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_att_pkg;

  localparam int unsigned CordW     = 28;  // CORDIC x/y/z datapath width
  localparam int unsigned IterW     = 5;   // index into the arctangent table
  localparam int unsigned AtanLen   = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic signed [17:0] RateToQ16 = 18'sd120158;
  localparam logic signed [17:0] GainInv   = 18'sd39797;
  localparam logic signed [17:0] BlendGyro = 18'sd64225;
  localparam logic signed [12:0] BlendAcc  = 13'sd1311;
  localparam logic signed [CordW-1:0] Deg180 = 28'sd11796480;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE      = 3'd0,
    REG_GZ_OFFSET   = 3'd1,
    REG_DEADBAND    = 3'd2,
    REG_DEFAULT_STEP = 3'd3,
    REG_MAX_STEP    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT1,
    ST_CORD1,
    ST_GAIN,
    ST_INIT2,
    ST_CORD2,
    ST_MUL1,
    ST_MUL2,
    ST_BLEND,
    ST_FIN
  } state_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [31:0]        timestamp_ms;
  } in_beat_t;

  typedef struct packed {
    logic               updated;
    logic signed [23:0] roll_deg;
    logic signed [23:0] pitch_deg;
    logic signed [23:0] yaw_deg;
  } out_beat_t;

  typedef struct packed {
    logic             load;       // capture the accepted beat
    logic             cord_init;  // seed CORDIC
    logic             cord_sel;   // 0: roll vector, 1: pitch vector
    logic             cord_iter;  // one micro-rotation
    logic [IterW-1:0] iter_idx;
    logic             gain;       // remove CORDIC gain, keep roll tilt
    logic             mul1;       // rate * step
    logic             mul2;       // scale to Q16.16 increment
    logic             blend;      // commit new angles
    logic             emit;       // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic enabled;
  } dp_sts_t;

  function automatic logic signed [CordW-1:0] atan_at(input logic [IterW-1:0] idx);
    logic signed [CordW-1:0] v;
    case (idx)
      5'd0:  v = 28'sd2949120;
      5'd1:  v = 28'sd1740967;
      5'd2:  v = 28'sd919879;
      5'd3:  v = 28'sd466945;
      5'd4:  v = 28'sd234379;
      5'd5:  v = 28'sd117267;
      5'd6:  v = 28'sd58666;
      5'd7:  v = 28'sd29335;
      5'd8:  v = 28'sd14668;
      5'd9:  v = 28'sd7334;
      5'd10: v = 28'sd3667;
      5'd11: v = 28'sd1833;
      5'd12: v = 28'sd917;
      5'd13: v = 28'sd458;
      5'd14: v = 28'sd229;
      5'd15: v = 28'sd115;
      5'd16: v = 28'sd57;
      5'd17: v = 28'sd29;
      5'd18: v = 28'sd14;
      5'd19: v = 28'sd7;
      5'd20: v = 28'sd4;
      5'd21: v = 28'sd2;
      5'd22: v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/imu_att_ctrl.sv
// ----------------------------------------------------------------------------
// imu_att_ctrl
// Sequencer: runs enabled samples through both CORDIC passes and the blend.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_att_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  input  imu_att_pkg::dp_sts_t  sts_i,
  output imu_att_pkg::dp_cmd_t  cmd_o
);
  import imu_att_pkg::*;

  localparam int unsigned CntW = $clog2(CORDIC_STEPS);
  localparam logic [CntW-1:0] LastIter = CntW'(CORDIC_STEPS - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovld_q, ovld_d;
  logic            accept;

  assign in_stall_o  = (state_q != ST_IDLE) | ovld_q;
  assign out_valid_o = ovld_q;
  assign accept      = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.is_clear || !sts_i.enabled) state_d = ST_FIN;
          else state_d = ST_INIT1;
        end
      end
      ST_INIT1: begin
        cnt_d   = '0;
        state_d = ST_CORD1;
      end
      ST_CORD1: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIter) state_d = ST_GAIN;
      end
      ST_GAIN:  state_d = ST_INIT2;
      ST_INIT2: begin
        cnt_d   = '0;
        state_d = ST_CORD2;
      end
      ST_CORD2: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIter) state_d = ST_MUL1;
      end
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_BLEND;
      ST_BLEND: state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.iter_idx = IterW'(cnt_q);
    ovld_d         = ovld_q & out_stall_i;
    case (state_q)
      ST_IDLE:  cmd_o.load = accept;
      ST_INIT1: cmd_o.cord_init = 1'b1;
      ST_CORD1: cmd_o.cord_iter = 1'b1;
      ST_GAIN:  cmd_o.gain = 1'b1;
      ST_INIT2: begin
        cmd_o.cord_init = 1'b1;
        cmd_o.cord_sel  = 1'b1;
      end
      ST_CORD2: cmd_o.cord_iter = 1'b1;
      ST_MUL1:  cmd_o.mul1 = 1'b1;
      ST_MUL2:  cmd_o.mul2 = 1'b1;
      ST_BLEND: cmd_o.blend = 1'b1;
      ST_FIN: begin
        cmd_o.emit = 1'b1;
        ovld_d     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

`default_nettype wire

### rtl/imu_att_dp.sv
// ----------------------------------------------------------------------------
// imu_att_dp
// Datapath: configuration, angle state, shared CORDIC and blend arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_att_dp (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_we_i,
  input  wire  [imu_att_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire  [imu_att_pkg::CfgDataW-1:0]        cfg_data_i,
  input  imu_att_pkg::in_beat_t                   in_data_i,
  input  imu_att_pkg::dp_cmd_t                    cmd_i,
  output imu_att_pkg::dp_sts_t                    sts_o,
  output imu_att_pkg::out_beat_t                  out_data_o
);
  import imu_att_pkg::*;

  // configuration
  logic               enable_q;
  logic signed [15:0] gz_off_q;
  logic [10:0]        deadband_q;
  logic [9:0]         def_step_q, max_step_q;

  // state
  logic signed [31:0] roll_q, pitch_q, yaw_q;
  logic [31:0]        last_time_q;

  // per-sample payload
  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic signed [16:0] dz_q;
  logic [9:0]         step_q;
  logic               upd_q;

  logic signed [CordW-1:0] cx_q, cy_q, cz_q, mag_q, racc_q;
  logic                    czero_q;
  logic signed [27:0]      gsx_q, gsy_q, gsz_q;
  logic signed [29:0]      incx_q, incy_q, incz_q;
  out_beat_t               out_q;

  logic [31:0]        diff;
  logic [9:0]         step_d;
  logic signed [16:0] dz_raw;
  logic [16:0]        dz_abs;

  assign sts_o.is_clear = (in_data_i.opcode == OP_CLEAR);
  assign sts_o.enabled  = enable_q;

  always_comb begin
    diff   = in_data_i.timestamp_ms - last_time_q;
    step_d = (diff == '0 || diff > {22'd0, max_step_q}) ? def_step_q : diff[9:0];
    dz_raw = {in_data_i.gyro_z[15], in_data_i.gyro_z} - {gz_off_q[15], gz_off_q};
    dz_abs = dz_raw[16] ? 17'(-dz_raw) : dz_raw;
  end

  // CORDIC seed and micro-rotation
  logic signed [CordW-1:0] xi, yi, sx, sy;
  logic                    ypos;
  always_comb begin
    if (cmd_i.cord_sel) begin
      xi = mag_q;
      yi = -(CordW'(ax_q) <<< 8);
    end else begin
      xi = CordW'(az_q) <<< 8;
      yi = CordW'(ay_q) <<< 8;
    end
    sx   = cx_q >>> cmd_i.iter_idx;
    sy   = cy_q >>> cmd_i.iter_idx;
    ypos = (cy_q > 0);
  end

  // arithmetic for gain, increments and blend
  logic signed [45:0] gain_p;
  logic signed [45:0] incx_p, incy_p, incz_p;
  logic signed [32:0] rsum, psum, ysum;
  logic signed [51:0] rbl, pbl;
  logic signed [CordW-1:0] pacc;
  logic signed [10:0] step_s;
  always_comb begin
    gain_p = 46'(cx_q) * 46'(GainInv);
    incx_p = 46'(gsx_q) * 46'(RateToQ16);
    incy_p = 46'(gsy_q) * 46'(RateToQ16);
    incz_p = 46'(gsz_q) * 46'(RateToQ16);
    step_s = $signed({1'b0, step_q});
    pacc   = czero_q ? '0 : cz_q;
    rsum   = 33'(roll_q) + 33'(incx_q);
    psum   = 33'(pitch_q) + 33'(incy_q);
    ysum   = 33'(yaw_q) + 33'(incz_q);
    rbl    = 52'(rsum) * 52'(BlendGyro) + 52'(racc_q) * 52'(BlendAcc) + 52'sd32768;
    pbl    = 52'(psum) * 52'(BlendGyro) + 52'(pacc) * 52'(BlendAcc) + 52'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      gz_off_q    <= '0;
      deadband_q  <= 11'd41;
      def_step_q  <= 10'd20;
      max_step_q  <= 10'd100;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      last_time_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE:       enable_q   <= cfg_data_i[0];
          REG_GZ_OFFSET:    gz_off_q   <= cfg_data_i;
          REG_DEADBAND:     deadband_q <= cfg_data_i[10:0];
          REG_DEFAULT_STEP: def_step_q <= cfg_data_i[9:0];
          REG_MAX_STEP:     max_step_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if (in_data_i.opcode == OP_CLEAR) begin
          roll_q  <= '0;
          pitch_q <= '0;
          yaw_q   <= '0;
        end else if (enable_q) begin
          last_time_q <= in_data_i.timestamp_ms;
        end
      end
      if (cmd_i.blend) begin
        roll_q  <= sat32(36'(rbl >>> 16));
        pitch_q <= sat32(36'(pbl >>> 16));
        yaw_q   <= sat32(36'(ysum));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= in_data_i.accel_x;
      ay_q   <= in_data_i.accel_y;
      az_q   <= in_data_i.accel_z;
      gx_q   <= in_data_i.gyro_x;
      gy_q   <= in_data_i.gyro_y;
      step_q <= step_d;
      dz_q   <= (dz_abs < {6'd0, deadband_q}) ? '0 : dz_raw;
      upd_q  <= (in_data_i.opcode == OP_CLEAR) | enable_q;
    end
    if (cmd_i.cord_init) begin
      czero_q <= (xi == '0) && (yi == '0);
      if (xi < 0) begin
        cx_q <= -xi;
        cy_q <= -yi;
        cz_q <= (yi >= 0) ? Deg180 : -Deg180;
      end else begin
        cx_q <= xi;
        cy_q <= yi;
        cz_q <= '0;
      end
    end
    if (cmd_i.cord_iter) begin
      if (ypos) begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + atan_at(cmd_i.iter_idx);
      end else begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - atan_at(cmd_i.iter_idx);
      end
    end
    if (cmd_i.gain) begin
      mag_q  <= CordW'((gain_p + 46'sd32768) >>> 16);
      racc_q <= czero_q ? '0 : cz_q;
    end
    if (cmd_i.mul1) begin
      gsx_q <= 28'(gx_q) * 28'(step_s);
      gsy_q <= 28'(gy_q) * 28'(step_s);
      gsz_q <= 28'(dz_q) * 28'(step_s);
    end
    if (cmd_i.mul2) begin
      incx_q <= 30'((incx_p + 46'sd32768) >>> 16);
      incy_q <= 30'((incy_p + 46'sd32768) >>> 16);
      incz_q <= 30'((incz_p + 46'sd32768) >>> 16);
    end
    if (cmd_i.emit) begin
      out_q.updated   <= upd_q;
      out_q.roll_deg  <= roll_q[31:8];
      out_q.pitch_deg <= pitch_q[31:8];
      out_q.yaw_deg   <= yaw_q[31:8];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### rtl/imu_complementary_attitude_top.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_top
// Roll/pitch/yaw complementary-filter attitude estimator.
// ----------------------------------------------------------------------------
//  channel  | signals                          | beat
//  ---------+----------------------------------+--------------------------
//  in       | in_valid_i, in_stall_o, in_data_i| one IMU sample or clear
//  out      | out_valid_o, out_stall_i, out_data_o | one angle report
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i  | one register write
//
//  A sample update runs two vectoring passes through one shared CORDIC unit.
//  A clear or disabled sample skips both passes. One sample is in work at a time.
//  A new sample is taken once the previous report has left the output register.
//  Reset clears the angles and the last timestamp and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_attitude_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  imu_att_pkg::in_beat_t              in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output imu_att_pkg::out_beat_t             out_data_o,
  input  wire                                cfg_we_i,
  input  wire  [imu_att_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [imu_att_pkg::CfgDataW-1:0]   cfg_data_i
);
  import imu_att_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  imu_att_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  imu_att_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the complementary-filter attitude estimator.
// A bit-exact predictor in the bench tracks roll, pitch, yaw and the last
// timestamp, and queues one expected report per accepted input beat. A
// checker compares each report leaving the block, field by field. Directed
// tests cover the register extremes and the corner cases. Random phases
// then drive timestamped streams, most with random idles on both sides.
// One phase holds the output off for a long time so that the block fills.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import imu_att_pkg::*;

  localparam int unsigned CordSteps = 16;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainCycles = 60;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam longint RateQ16 = 120158;
  localparam longint GainQ16 = 39797;
  localparam longint GyroBlend = 64225;
  localparam longint AccBlend = 1311;
  localparam longint HalfTurn = 11796480;
  localparam longint AngleMax = 64'sd2147483647;
  localparam longint AngleMin = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  imu_complementary_attitude_top #(.CORDIC_STEPS(CordSteps)) u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted attitude state and register copy
  longint roll_q16, pitch_q16, yaw_q16;
  logic [31:0] prev_stamp;
  logic att_enable;
  longint zrate_offset;
  longint zrate_deadband;
  longint fallback_step;
  longint step_ceiling;

  out_beat_t report_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int unsigned rx_hold_req = 0;
  logic [31:0] stamp_cursor = '0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      out_stall <= 1'b1;
      rx_hold_req = rx_hold_req - 1;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(0, 99) < 37);
    end
  end

  // stall and valid settle between edges; a beat seen here moves at the next edge
  always @(negedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %h", out_data);
      end else begin
        want = report_q.pop_front();
        if (out_data.updated !== want.updated || out_data.roll_deg !== want.roll_deg ||
            out_data.pitch_deg !== want.pitch_deg || out_data.yaw_deg !== want.yaw_deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: exp upd=%0d r=%0d p=%0d y=%0d got upd=%0d r=%0d p=%0d y=%0d",
                     want.updated, want.roll_deg, want.pitch_deg, want.yaw_deg,
                     out_data.updated, out_data.roll_deg, out_data.pitch_deg,
                     out_data.yaw_deg);
        end
      end
    end
  end

  function automatic longint rnd_q16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > AngleMax) return AngleMax;
    if (v < AngleMin) return AngleMin;
    return v;
  endfunction

  // vectoring CORDIC: raw magnitude (gain kept) and angle in Q16.16 degrees
  function automatic void vector_angle(input longint x0, input longint y0,
                                       output longint mag, output longint ang);
    longint x, y, z, nx, ny;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordSteps && i < AtanLen; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(atan_at(i[IterW-1:0]));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(atan_at(i[IterW-1:0]));
      end
      x = nx;
      y = ny;
    end
    mag = x;
    ang = z;
  endfunction

  function automatic out_beat_t angle_report(input logic upd);
    out_beat_t r;
    longint tr, tp, ty;
    tr = roll_q16 >>> 8;
    tp = pitch_q16 >>> 8;
    ty = yaw_q16 >>> 8;
    r.updated = upd;
    r.roll_deg = tr[23:0];
    r.pitch_deg = tp[23:0];
    r.yaw_deg = ty[23:0];
    return r;
  endfunction

  function automatic out_beat_t update_attitude(input in_beat_t s);
    longint ax, ay, az, gx, gy, gz, step, dz, raw_mag, mag, roll_tilt, pitch_tilt, spare;
    logic [31:0] diff;
    if (s.opcode == OP_CLEAR) begin
      roll_q16 = 0;
      pitch_q16 = 0;
      yaw_q16 = 0;
      return angle_report(1'b1);
    end
    if (!att_enable) return angle_report(1'b0);
    ax = longint'($signed(s.accel_x));
    ay = longint'($signed(s.accel_y));
    az = longint'($signed(s.accel_z));
    gx = longint'($signed(s.gyro_x));
    gy = longint'($signed(s.gyro_y));
    gz = longint'($signed(s.gyro_z));
    diff = s.timestamp_ms - prev_stamp;
    prev_stamp = s.timestamp_ms;
    if (diff == 0 || longint'(diff) > step_ceiling) step = fallback_step;
    else step = longint'(diff);
    dz = gz - zrate_offset;
    if (((dz < 0) ? -dz : dz) < zrate_deadband) dz = 0;
    vector_angle(az * 256, ay * 256, raw_mag, roll_tilt);
    mag = rnd_q16(raw_mag * GainQ16);
    vector_angle(mag, -ax * 256, spare, pitch_tilt);
    roll_q16 = clamp32(rnd_q16(GyroBlend * (roll_q16 + rnd_q16(gx * step * RateQ16))
                               + AccBlend * roll_tilt));
    pitch_q16 = clamp32(rnd_q16(GyroBlend * (pitch_q16 + rnd_q16(gy * step * RateQ16))
                                + AccBlend * pitch_tilt));
    yaw_q16 = clamp32(yaw_q16 + rnd_q16(dz * step * RateQ16));
    return angle_report(1'b1);
  endfunction

  task automatic send_beat(input in_beat_t b);
    bit took;
    in_valid <= 1'b1;
    in_data <= b;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    report_q.push_back(update_attitude(b));
    if (tx_idle_on && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drop valid and let every report out before touching registers
  task automatic settle;
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ENABLE: att_enable = val[0];
      REG_GZ_OFFSET: zrate_offset = longint'($signed(val));
      REG_DEADBAND: zrate_deadband = longint'(val[10:0]);
      REG_DEFAULT_STEP: fallback_step = longint'(val[9:0]);
      REG_MAX_STEP: step_ceiling = longint'(val[9:0]);
      default: ;
    endcase
  endtask

  task automatic setup_regs(input bit en, input int off, input int db, input int dstep,
                            input int mstep);
    settle();
    write_reg(REG_ENABLE, {{(CfgDataW-1){1'b0}}, en});
    write_reg(REG_GZ_OFFSET, off[15:0]);
    write_reg(REG_DEADBAND, db[15:0]);
    write_reg(REG_DEFAULT_STEP, dstep[15:0]);
    write_reg(REG_MAX_STEP, mstep[15:0]);
  endtask

  function automatic in_beat_t imu_sample(input int ax, input int ay, input int az,
                                          input int gx, input int gy, input int gz,
                                          input logic [31:0] ts);
    in_beat_t b;
    b.opcode = OP_SAMPLE;
    b.accel_x = ax[15:0];
    b.accel_y = ay[15:0];
    b.accel_z = az[15:0];
    b.gyro_x = gx[15:0];
    b.gyro_y = gy[15:0];
    b.gyro_z = gz[15:0];
    b.timestamp_ms = ts;
    return b;
  endfunction

  function automatic in_beat_t clear_beat();
    in_beat_t b;
    b = in_beat_t'({1'b0, $urandom, $urandom, $urandom, $urandom});
    b.opcode = OP_CLEAR;
    return b;
  endfunction

  // mostly plausible motion with a steady clock; now and then raw noise, a clear or a time jump
  function automatic in_beat_t random_sample();
    in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return clear_beat();
    if (pick < 13) begin
      b = in_beat_t'({1'b0, $urandom, $urandom, $urandom, $urandom});
      b.opcode = OP_SAMPLE;
      if ($urandom_range(0, 1)) stamp_cursor = b.timestamp_ms;
      return b;
    end
    if (pick < 18) stamp_cursor += $urandom_range(100, 5000);
    else stamp_cursor += $urandom_range(0, 130);
    return imu_sample($urandom_range(0, 6000) - 3000, $urandom_range(0, 6000) - 3000,
                      $urandom_range(0, 6000) - 500, $urandom_range(0, 36000) - 18000,
                      $urandom_range(0, 36000) - 18000, $urandom_range(0, 36000) - 18000,
                      stamp_cursor);
  endfunction

  task automatic test_idle_after_reset;
    send_beat(imu_sample(100, 200, 2500, 500, -500, 800, 32'd10));
    send_beat(clear_beat());
  endtask

  task automatic test_corner_samples;
    setup_regs(1'b1, 0, 41, 20, 100);
    send_beat(imu_sample(0, 0, 0, 0, 0, 0, 32'd0));
    send_beat(imu_sample(32767, 32767, 32767, 18000, 18000, 18000, 32'd5));
    send_beat(imu_sample(-32768, -32768, -32768, -18000, -18000, -18000, 32'd105));
    send_beat(imu_sample(0, 1000, -2500, 0, 0, 0, 32'd106));
    send_beat(imu_sample(0, -1000, -2500, 0, 0, 0, 32'd206));
    send_beat(imu_sample(0, 0, -2500, 40, 0, 41, 32'd207));
    send_beat(imu_sample(0, 0, 2500, 0, 0, -41, 32'd207));
    send_beat(imu_sample(0, 0, 2500, -32768, 32767, 32767, 32'hFFFF_FFF0));
    send_beat(imu_sample(2500, 0, 0, 0, 0, -40, 32'h0000_0005));
    send_beat(clear_beat());
    send_beat(imu_sample(-2500, 0, 0, 100, -100, 100, 32'hFFFF_FFFF));
    send_beat(imu_sample(0, 2500, 0, 0, 0, 0, 32'h0000_0063));
  endtask

  task automatic test_register_extremes;
    setup_regs(1'b1, 18000, 0, 0, 0);
    send_beat(imu_sample(100, 200, 2500, 18000, 18000, 0, 32'd300));
    send_beat(imu_sample(100, 200, 2500, -18000, 18000, -18000, 32'd301));
    setup_regs(1'b1, -18000, 2047, 1000, 1000);
    send_beat(imu_sample(0, 0, 2500, 100, 100, 0, 32'd1301));
    send_beat(imu_sample(0, 0, 2500, 100, 100, -15953, 32'd2302));
    setup_regs(1'b1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(RegUnused, 16'h0000);
    send_beat(imu_sample(0, 0, 2500, 32767, -32768, 32767, 32'd2400));
    send_beat(imu_sample(0, 0, 2500, 32767, -32768, 32767, 32'd2400));
    for (int k = 0; k < 8; k++)
      send_beat(imu_sample(0, 0, 0, 32767, -32768, 32767, 32'd2400 + k + 1));
    setup_regs(1'b0, 0, 41, 20, 100);
    send_beat(imu_sample(0, 0, 2500, 100, 100, 100, 32'd9000));
  endtask

  task automatic test_random_phases;
    int db_pick[4];
    db_pick = '{0, 41, 300, 2047};
    for (int ph = 0; ph < 8; ph++) begin
      setup_regs(ph != 5, $urandom_range(0, 36000) - 18000, db_pick[ph % 4],
                 (ph == 2) ? 1000 : $urandom_range(0, 60),
                 (ph == 3) ? 1 : $urandom_range(1, 1000));
      tx_idle_on = (ph != 1);
      rx_idle_on = (ph != 1);
      for (int n = 0; n < 210; n++) begin
        if (ph == 4 && n == 20) rx_hold_req = 400;
        send_beat(random_sample());
      end
    end
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    att_enable = 1'b0;
    zrate_offset = 0;
    zrate_deadband = 41;
    fallback_step = 20;
    step_ceiling = 100;
    roll_q16 = 0;
    pitch_q16 = 0;
    yaw_q16 = 0;
    prev_stamp = '0;
    @(posedge clk);
    test_idle_after_reset();
    test_corner_samples();
    test_register_extremes();
    test_random_phases();
    settle();
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/imu_att_pkg.sv
rtl/imu_att_ctrl.sv
rtl/imu_att_dp.sv
rtl/imu_complementary_attitude_top.sv
verif/tb_top.sv
